// ===== src/ppm_pkg.sv =====
package ppm_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_TIME       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANNEL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_TIMEOUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_CHANNEL   = 3'd6;

    // reset values of the registers
    localparam logic [4:0]  RST_CHANNEL_COUNT    = 5'd8;
    localparam logic [15:0] RST_BLANK_TIME       = 16'd2100;
    localparam logic [11:0] RST_MIN_CHANNEL      = 12'd1000;
    localparam logic [11:0] RST_MAX_CHANNEL      = 12'd2000;
    localparam logic [9:0]  RST_MAX_ERROR        = 10'd10;
    localparam logic [31:0] RST_FAILSAFE_TIMEOUT = 32'd500000;
    localparam logic [3:0]  RST_SWITCH_CHANNEL   = 4'd6;

    // item opcodes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // three-position switch thresholds
    localparam logic [15:0] SWITCH_LOW  = 16'd1100;
    localparam logic [15:0] SWITCH_HIGH = 16'd1600;

    // motor line codes: bit 0 motor_a, bit 1 motor_b
    localparam logic [1:0] MOTOR_OFF = 2'b00;
    localparam logic [1:0] MOTOR_A   = 2'b01;
    localparam logic [1:0] MOTOR_B   = 2'b10;

    localparam logic [7:0] SLOT_MAX = 8'hFF;

    typedef struct packed {
        logic        op;
        logic [31:0] now_us;
        logic [7:0]  channel;
        logic [15:0] default_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] raw_value;
        logic [15:0] channel_value;
        logic        motor_a;
        logic        motor_b;
        logic        frame_end;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  channel_count;
        logic [15:0] blank_time;
        logic [11:0] min_channel_value;
        logic [11:0] max_channel_value;
        logic [9:0]  max_error;
        logic [31:0] failsafe_timeout;
        logic [3:0]  switch_channel;
    } t_cfg;

    // store write request, slot is truncated to the store index inside the store
    typedef struct packed {
        logic        raw_we;
        logic        val_we;
        logic [7:0]  slot;
        logic [15:0] raw;
        logic [15:0] val;
    } t_wr_req;

    // registered store read data, never-written entries read as zero
    typedef struct packed {
        logic [15:0] raw;
        logic [15:0] val;
        logic [15:0] sw;
    } t_rd_data;

    typedef struct packed {
        logic [31:0] last_edge;
        logic [7:0]  slot;
        logic [1:0]  motor;
    } t_state_upd;

endpackage

// ===== src/ppm_in_if.sv =====
interface ppm_in_if;
    logic               valid;
    logic               ready;
    ppm_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ppm_out_if.sv =====
interface ppm_out_if;
    logic               valid;
    logic               ready;
    ppm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ppm_cfg_regs.sv =====
module ppm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [ppm_pkg::CFG_DATA_W-1:0] i_data,
    output ppm_pkg::t_cfg                  o_cfg
);

    ppm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count     <= ppm_pkg::RST_CHANNEL_COUNT;
            r_cfg.blank_time        <= ppm_pkg::RST_BLANK_TIME;
            r_cfg.min_channel_value <= ppm_pkg::RST_MIN_CHANNEL;
            r_cfg.max_channel_value <= ppm_pkg::RST_MAX_CHANNEL;
            r_cfg.max_error         <= ppm_pkg::RST_MAX_ERROR;
            r_cfg.failsafe_timeout  <= ppm_pkg::RST_FAILSAFE_TIMEOUT;
            r_cfg.switch_channel    <= ppm_pkg::RST_SWITCH_CHANNEL;
        end else if (i_we) begin
            case (i_idx)
                ppm_pkg::REG_CHANNEL_COUNT:    r_cfg.channel_count     <= i_data[4:0];
                ppm_pkg::REG_BLANK_TIME:       r_cfg.blank_time        <= i_data[15:0];
                ppm_pkg::REG_MIN_CHANNEL:      r_cfg.min_channel_value <= i_data[11:0];
                ppm_pkg::REG_MAX_CHANNEL:      r_cfg.max_channel_value <= i_data[11:0];
                ppm_pkg::REG_MAX_ERROR:        r_cfg.max_error         <= i_data[9:0];
                ppm_pkg::REG_FAILSAFE_TIMEOUT: r_cfg.failsafe_timeout  <= i_data;
                ppm_pkg::REG_SWITCH_CHANNEL:   r_cfg.switch_channel    <= i_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/ppm_store.sv =====
module ppm_store #(
    parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppm_pkg::t_wr_req                i_wr,
    input  logic                            i_rd_en,
    input  logic [$clog2(MAX_CHANNELS)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_CHANNELS)-1:0] i_sw_addr,
    input  logic                            i_sw_ok,
    output ppm_pkg::t_rd_data               o_rd
);

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    logic [15:0]             r_raw_mem [MAX_CHANNELS];
    logic [15:0]             r_val_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_raw_vld;
    logic [MAX_CHANNELS-1:0] r_val_vld;
    logic [15:0]             r_rd_raw;
    logic [15:0]             r_rd_val;
    logic [15:0]             r_rd_sw;
    logic [IDX_W-1:0]        wr_addr;

    assign wr_addr = i_wr.slot[IDX_W-1:0];

    // valid bits stand in for clearing the stores at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_vld <= '0;
            r_val_vld <= '0;
        end else begin
            if (i_wr.raw_we) r_raw_vld[wr_addr] <= 1'b1;
            if (i_wr.val_we) r_val_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.raw_we) r_raw_mem[wr_addr] <= i_wr.raw;
        if (i_wr.val_we) r_val_mem[wr_addr] <= i_wr.val;
    end

    // registered reads, write-first on an address match
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.raw_we && wr_addr == i_rd_addr) begin
                r_rd_raw <= i_wr.raw;
            end else begin
                r_rd_raw <= r_raw_vld[i_rd_addr] ? r_raw_mem[i_rd_addr] : 16'd0;
            end
            if (i_wr.val_we && wr_addr == i_rd_addr) begin
                r_rd_val <= i_wr.val;
            end else begin
                r_rd_val <= r_val_vld[i_rd_addr] ? r_val_mem[i_rd_addr] : 16'd0;
            end
        end
        if (!i_sw_ok) begin
            r_rd_sw <= 16'd0;
        end else if (i_wr.val_we && wr_addr == i_sw_addr) begin
            r_rd_sw <= i_wr.val;
        end else begin
            r_rd_sw <= r_val_vld[i_sw_addr] ? r_val_mem[i_sw_addr] : 16'd0;
        end
    end

    assign o_rd.raw = r_rd_raw;
    assign o_rd.val = r_rd_val;
    assign o_rd.sw  = r_rd_sw;

endmodule

// ===== src/ppm_decode.sv =====
module ppm_decode #(
    parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEF
) (
    input  ppm_pkg::t_in_item   i_item,
    input  logic                i_good,
    input  ppm_pkg::t_rd_data   i_rd,
    input  ppm_pkg::t_cfg       i_cfg,
    input  logic [31:0]         i_last_edge,
    input  logic [7:0]          i_slot,
    input  logic [1:0]          i_motor,
    output ppm_pkg::t_out_item  o_res,
    output ppm_pkg::t_state_upd o_upd,
    output ppm_pkg::t_wr_req    o_wr
);

    logic [31:0] interval;
    logic        is_edge;
    logic        frame;
    logic [11:0] lo;
    logic [12:0] hi;
    logic        in_rng;
    logic [15:0] clamped;
    logic        slot_ok;
    logic [1:0]  sw_motor;
    logic [7:0]  slot_inc;
    logic [15:0] rd_val;
    logic [1:0]  motor_nxt;

    assign interval = i_item.now_us - i_last_edge;
    assign is_edge  = (i_item.op == ppm_pkg::OP_EDGE);
    assign frame    = interval > {16'd0, i_cfg.blank_time};

    // tolerance window, floor saturates at zero
    assign lo = (i_cfg.min_channel_value > {2'd0, i_cfg.max_error})
              ? i_cfg.min_channel_value - {2'd0, i_cfg.max_error} : 12'd0;
    assign hi = {1'b0, i_cfg.max_channel_value} + {3'd0, i_cfg.max_error};
    assign in_rng = (interval >= {20'd0, lo}) && (interval <= {19'd0, hi});

    always_comb begin
        if (interval < {20'd0, i_cfg.min_channel_value}) begin
            clamped = {4'd0, i_cfg.min_channel_value};
        end else if (interval > {20'd0, i_cfg.max_channel_value}) begin
            clamped = {4'd0, i_cfg.max_channel_value};
        end else begin
            clamped = interval[15:0];
        end
    end

    assign slot_ok = (i_slot < {3'd0, i_cfg.channel_count})
                  && ({24'd0, i_slot} < 32'(MAX_CHANNELS));

    always_comb begin
        if (i_rd.sw < ppm_pkg::SWITCH_LOW) begin
            sw_motor = ppm_pkg::MOTOR_OFF;
        end else if (i_rd.sw < ppm_pkg::SWITCH_HIGH) begin
            sw_motor = ppm_pkg::MOTOR_A;
        end else begin
            sw_motor = ppm_pkg::MOTOR_B;
        end
    end

    assign slot_inc = (i_slot != ppm_pkg::SLOT_MAX) ? i_slot + 8'd1 : i_slot;

    // read value: default on bad channel, below-min entry or failsafe timeout
    always_comb begin
        rd_val = i_item.default_value;
        if (i_good && i_rd.val >= {4'd0, i_cfg.min_channel_value}) begin
            rd_val = i_rd.val;
        end
        if (interval > i_cfg.failsafe_timeout) begin
            rd_val = i_item.default_value;
        end
    end

    assign motor_nxt = (is_edge && frame) ? sw_motor : i_motor;

    always_comb begin
        o_upd.last_edge = is_edge ? i_item.now_us : i_last_edge;
        o_upd.slot      = is_edge ? (frame ? 8'd0 : slot_inc) : i_slot;
        o_upd.motor     = motor_nxt;

        o_wr.raw_we = is_edge && !frame && slot_ok;
        o_wr.val_we = is_edge && !frame && slot_ok && in_rng;
        o_wr.slot   = i_slot;
        o_wr.raw    = interval[15:0];
        o_wr.val    = clamped;

        o_res.raw_value     = (!is_edge && i_good) ? i_rd.raw : 16'd0;
        o_res.channel_value = is_edge ? 16'd0 : rd_val;
        o_res.motor_a       = motor_nxt[0];
        o_res.motor_b       = motor_nxt[1];
        o_res.frame_end     = is_edge && frame;
    end

endmodule

// ===== src/ppm_frame_decoder.sv =====
// PPM frame decoder: input register, then decode into the output register.
// A request is held in the input register and its decoded result in the output register.
// Throughput: one request per cycle, set by the single decode stage and one
// write port per channel store; stalls only when the output register is held.
// Reset (synchronous, active low) restores register defaults, clears timing
// and motor state, and clears both stores at once through per-entry valid bits.
module ppm_frame_decoder #(
    parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ppm_in_if.sink                         i_in,
    ppm_out_if.source                      o_out
);

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    ppm_pkg::t_cfg       cfg;
    ppm_pkg::t_rd_data   rd;
    ppm_pkg::t_out_item  dec_res;
    ppm_pkg::t_state_upd dec_upd;
    ppm_pkg::t_wr_req    dec_wr;
    ppm_pkg::t_wr_req    wr;

    logic               accept;
    logic               commit;
    logic               rd_good;
    logic [IDX_W-1:0]   rd_addr;
    logic               sw_ok;
    logic [IDX_W-1:0]   sw_addr;

    logic               r_s1_valid;
    ppm_pkg::t_in_item  r_s1;
    logic               r_s1_good;
    logic               r_out_valid;
    ppm_pkg::t_out_item r_out;
    logic [31:0]        r_last_edge;
    logic [7:0]         r_slot;
    logic [1:0]         r_motor;

    ppm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Handshake: stage 1 retires into the output register whenever that
    // register is empty or being drained; a new request enters behind it.
    assign commit      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || commit;
    assign accept      = i_in.valid && i_in.ready;

    // Read request: channel is one-based; a bad channel reads entry zero
    // and is masked in decode.
    assign rd_good = (i_in.payload.channel != 8'd0)
                  && (i_in.payload.channel <= {3'd0, cfg.channel_count})
                  && ({24'd0, i_in.payload.channel} <= 32'(MAX_CHANNELS));
    assign rd_addr = rd_good ? IDX_W'(i_in.payload.channel - 8'd1) : '0;

    // Switch slot beyond the store reads as zero.
    assign sw_ok   = {28'd0, cfg.switch_channel} < 32'(MAX_CHANNELS);
    assign sw_addr = sw_ok ? IDX_W'(cfg.switch_channel) : '0;

    // Drop store writes unless the stage-1 request actually retires.
    always_comb begin
        wr        = dec_wr;
        wr.raw_we = dec_wr.raw_we && commit;
        wr.val_we = dec_wr.val_we && commit;
    end

    ppm_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_sw_addr (sw_addr),
        .i_sw_ok   (sw_ok),
        .o_rd      (rd)
    );

    ppm_decode #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_decode (
        .i_item      (r_s1),
        .i_good      (r_s1_good),
        .i_rd        (rd),
        .i_cfg       (cfg),
        .i_last_edge (r_last_edge),
        .i_slot      (r_slot),
        .i_motor     (r_motor),
        .o_res       (dec_res),
        .o_upd       (dec_upd),
        .o_wr        (dec_wr)
    );

    // Stage-1, output and decoder state control: hold while the output side stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_edge <= 32'd0;
            r_slot      <= 8'd0;
            r_motor     <= ppm_pkg::MOTOR_OFF;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_last_edge <= dec_upd.last_edge;
                r_slot      <= dec_upd.slot;
                r_motor     <= dec_upd.motor;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= i_in.payload;
            r_s1_good <= rd_good;
        end
        if (commit) begin
            r_out <= dec_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // An accepted request always occupies stage 1 in the next cycle.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request did not reach stage 1");

    // A frame end restarts the slot counter.
    a_frame_clears_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && dec_res.frame_end) |=> (r_slot == 8'd0))
        else $error("slot counter not cleared at frame end");

    // Slot counter moves only when a request retires.
    a_slot_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_slot))
        else $error("slot counter changed without a retiring request");

    // The switch never drives both motor lines.
    a_motor_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.payload.motor_a && o_out.payload.motor_b))
        else $error("both motor lines driven");

endmodule
